>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the checker modules of this project.
// Include with the bare file name; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked assertion that is also checked while reset is asserted.
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

>>> hw/rtl/cpmg_pkg.sv
// Package for the complex pixel magnitude to gray pipeline.
// Holds widths, stage counts, the control struct and the square root step.
// No dependencies.
package cpmg_pkg;

    localparam int PixW          = 8;
    localparam int SumW          = 16;
    localparam int RootShift     = 17;
    localparam int StepsPerStage = 2;

    localparam int Root1Bits     = 17;
    localparam int Rad1W         = 2 * Root1Bits;
    localparam int Root1Stages   = (Root1Bits + StepsPerStage - 1) / StepsPerStage;

    localparam int Root2Bits     = 9;
    localparam int Rad2W         = 2 * Root2Bits;
    localparam int Root2Stages   = (Root2Bits + StepsPerStage - 1) / StepsPerStage;

    localparam int RemW          = 20;
    localparam int RootW         = Root1Bits;

    localparam logic [PixW-1:0] CentreOffset = 8'd128;
    localparam logic [PixW-1:0] GrayMax      = 8'd255;

    typedef struct packed {
        logic valid;
        logic last;
    } t_ctl;

    typedef logic [RemW-1:0]  t_rem;
    typedef logic [RootW-1:0] t_root;

    typedef struct packed {
        t_rem  rem;
        t_root root;
    } t_sq_state;

    function automatic t_sq_state sqrt_step(t_sq_state st, logic [1:0] pair);
        t_rem      cur;
        t_rem      trial;
        t_sq_state nx;
        cur   = {st.rem[RemW-3:0], pair};
        trial = {1'b0, st.root, 2'b01};
        if (cur >= trial) begin
            nx.rem  = cur - trial;
            nx.root = {st.root[RootW-2:0], 1'b1};
        end else begin
            nx.rem  = cur;
            nx.root = {st.root[RootW-2:0], 1'b0};
        end
        return nx;
    endfunction

endpackage

>>> hw/rtl/cpmg_sqsum.sv
// Centering, squaring and summing of the real and imaginary bytes.
// Three register stages; depends on cpmg_pkg.
module cpmg_sqsum (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_ce,
    input  cpmg_pkg::t_ctl              i_ctl,
    input  logic [cpmg_pkg::PixW-1:0]   i_re_byte,
    input  logic [cpmg_pkg::PixW-1:0]   i_im_byte,
    output cpmg_pkg::t_ctl              o_ctl,
    output logic [cpmg_pkg::SumW-1:0]   o_sum
);
    import cpmg_pkg::*;

    t_ctl              r_ctl1, r_ctl2, r_ctl3;
    logic [PixW-1:0]   r_re_abs, r_im_abs, n_re_abs, n_im_abs;
    logic [SumW-1:0]   r_re_sq, r_im_sq, n_re_sq, n_im_sq;
    logic [SumW-1:0]   r_sum, n_sum;

    always_comb begin
        n_re_abs = i_re_byte[PixW-1] ? {1'b0, i_re_byte[PixW-2:0]} : (CentreOffset - i_re_byte);
        n_im_abs = i_im_byte[PixW-1] ? {1'b0, i_im_byte[PixW-2:0]} : (CentreOffset - i_im_byte);
        n_re_sq  = SumW'(r_re_abs) * SumW'(r_re_abs);
        n_im_sq  = SumW'(r_im_abs) * SumW'(r_im_abs);
        n_sum    = r_re_sq + r_im_sq;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1 <= '0;
            r_ctl2 <= '0;
            r_ctl3 <= '0;
        end else if (i_ce) begin
            r_ctl1 <= i_ctl;
            r_ctl2 <= r_ctl1;
            r_ctl3 <= r_ctl2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_re_abs <= n_re_abs;
            r_im_abs <= n_im_abs;
            r_re_sq  <= n_re_sq;
            r_im_sq  <= n_im_sq;
            r_sum    <= n_sum;
        end
    end

    assign o_ctl = r_ctl3;
    assign o_sum = r_sum;

endmodule

>>> hw/rtl/cpmg_root_hi.sv
// Pipelined restoring square root of the scaled sum, at most two result bits per stage.
// Depends on cpmg_pkg.
module cpmg_root_hi (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_ce,
    input  cpmg_pkg::t_ctl              i_ctl,
    input  logic [cpmg_pkg::SumW-1:0]   i_sum,
    output cpmg_pkg::t_ctl              o_ctl,
    output logic [cpmg_pkg::RootW-1:0]  o_root
);
    import cpmg_pkg::*;

    t_ctl             r_ctl [Root1Stages];
    t_sq_state        r_st  [Root1Stages];
    logic [Rad1W-1:0] r_rad [Root1Stages];
    t_sq_state        n_st  [Root1Stages];
    logic [Rad1W-1:0] n_rad [Root1Stages];

    for (genvar j = 0; j < Root1Stages; j++) begin : g_stage
        t_sq_state        st_in;
        logic [Rad1W-1:0] rad_in;
        t_sq_state        st_loc;
        logic [Rad1W-1:0] rad_loc;

        if (j == 0) begin : g_first
            assign st_in  = '0;
            assign rad_in = {{(Rad1W-SumW-RootShift){1'b0}}, i_sum, {RootShift{1'b0}}};
        end else begin : g_next
            assign st_in  = r_st[j-1];
            assign rad_in = r_rad[j-1];
        end

        always_comb begin
            st_loc  = st_in;
            rad_loc = rad_in;
            for (int k = 0; k < StepsPerStage; k++) begin
                if (j * StepsPerStage + k < Root1Bits) begin
                    st_loc  = sqrt_step(st_loc, rad_loc[Rad1W-1 -: 2]);
                    rad_loc = rad_loc << 2;
                end
            end
        end

        assign n_st[j]  = st_loc;
        assign n_rad[j] = rad_loc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < Root1Stages; j++) begin
                r_ctl[j] <= '0;
            end
        end else if (i_ce) begin
            r_ctl[0] <= i_ctl;
            for (int j = 1; j < Root1Stages; j++) begin
                r_ctl[j] <= r_ctl[j-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            for (int j = 0; j < Root1Stages; j++) begin
                r_st[j]  <= n_st[j];
                r_rad[j] <= n_rad[j];
            end
        end
    end

    assign o_ctl  = r_ctl[Root1Stages-1];
    assign o_root = r_st[Root1Stages-1].root;

endmodule

>>> hw/rtl/cpmg_root_lo.sv
// Pipelined restoring square root of the first root, giving the fourth root.
// Depends on cpmg_pkg.
module cpmg_root_lo (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_ce,
    input  cpmg_pkg::t_ctl                  i_ctl,
    input  logic [cpmg_pkg::RootW-1:0]      i_root,
    output cpmg_pkg::t_ctl                  o_ctl,
    output logic [cpmg_pkg::Root2Bits-1:0]  o_root
);
    import cpmg_pkg::*;

    t_ctl             r_ctl [Root2Stages];
    t_sq_state        r_st  [Root2Stages];
    logic [Rad2W-1:0] r_rad [Root2Stages];
    t_sq_state        n_st  [Root2Stages];
    logic [Rad2W-1:0] n_rad [Root2Stages];

    for (genvar j = 0; j < Root2Stages; j++) begin : g_stage
        t_sq_state        st_in;
        logic [Rad2W-1:0] rad_in;
        t_sq_state        st_loc;
        logic [Rad2W-1:0] rad_loc;

        if (j == 0) begin : g_first
            assign st_in  = '0;
            assign rad_in = {{(Rad2W-RootW){1'b0}}, i_root};
        end else begin : g_next
            assign st_in  = r_st[j-1];
            assign rad_in = r_rad[j-1];
        end

        always_comb begin
            st_loc  = st_in;
            rad_loc = rad_in;
            for (int k = 0; k < StepsPerStage; k++) begin
                if (j * StepsPerStage + k < Root2Bits) begin
                    st_loc  = sqrt_step(st_loc, rad_loc[Rad2W-1 -: 2]);
                    rad_loc = rad_loc << 2;
                end
            end
        end

        assign n_st[j]  = st_loc;
        assign n_rad[j] = rad_loc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < Root2Stages; j++) begin
                r_ctl[j] <= '0;
            end
        end else if (i_ce) begin
            r_ctl[0] <= i_ctl;
            for (int j = 1; j < Root2Stages; j++) begin
                r_ctl[j] <= r_ctl[j-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            for (int j = 0; j < Root2Stages; j++) begin
                r_st[j]  <= n_st[j];
                r_rad[j] <= n_rad[j];
            end
        end
    end

    assign o_ctl  = r_ctl[Root2Stages-1];
    assign o_root = r_st[Root2Stages-1].root[Root2Bits-1:0];

endmodule

>>> hw/rtl/complex_pixel_magnitude_gray.sv
// Complex pixel to gray level: gray = floor of the fourth root of (re^2 + im^2) * 2^17, saturated at 255.
// Each pixel passes the square-sum stages, both root pipelines and the output register, in that order.
// Throughput is one pixel per cycle; the whole pipeline stalls only while the output is held.
// The fourth root is two chained pipelined square roots, at most two result bits per stage.
// Reset (i_rst_n low, synchronous) clears all valid bits; no pixel survives it.
module complex_pixel_magnitude_gray (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // re_byte [7:0], im_byte [15:8]
    input  logic        i_s_axis_tlast,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,   // gray [7:0]
    output logic        o_m_axis_tlast
);
    import cpmg_pkg::*;

    logic                 ce;
    t_ctl                 in_ctl, sq_ctl, hi_ctl, lo_ctl;
    logic [SumW-1:0]      sum;
    logic [RootW-1:0]     root_hi;
    logic [Root2Bits-1:0] root_lo;
    t_ctl                 r_out_ctl;
    logic [PixW-1:0]      r_gray, n_gray;

    assign ce              = !r_out_ctl.valid || i_m_axis_tready;
    assign in_ctl.valid    = i_s_axis_tvalid;
    assign in_ctl.last     = i_s_axis_tlast;

    cpmg_sqsum u_sqsum (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ce      (ce),
        .i_ctl     (in_ctl),
        .i_re_byte (i_s_axis_tdata[PixW-1:0]),
        .i_im_byte (i_s_axis_tdata[2*PixW-1:PixW]),
        .o_ctl     (sq_ctl),
        .o_sum     (sum)
    );

    cpmg_root_hi u_root_hi (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_ctl   (sq_ctl),
        .i_sum   (sum),
        .o_ctl   (hi_ctl),
        .o_root  (root_hi)
    );

    cpmg_root_lo u_root_lo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_ctl   (hi_ctl),
        .i_root  (root_hi),
        .o_ctl   (lo_ctl),
        .o_root  (root_lo)
    );

    assign n_gray = root_lo[Root2Bits-1] ? GrayMax : root_lo[PixW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_ctl <= '0;
        end else if (ce) begin
            r_out_ctl <= lo_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_gray <= n_gray;
        end
    end

    assign o_s_axis_tready = ce;
    assign o_m_axis_tvalid = r_out_ctl.valid;
    assign o_m_axis_tdata  = r_gray;
    assign o_m_axis_tlast  = r_out_ctl.last;

endmodule

>>> hw/rtl/cpmg_checker.sv
// Port-level checker for complex_pixel_magnitude_gray, attached by bind.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module cpmg_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [7:0]  o_m_axis_tdata,
    input logic        o_m_axis_tlast
);

    `ASSERT_CLK_ALWAYS(a_reset_clears_out, !i_rst_n |=> !o_m_axis_tvalid, "output valid after reset")

    `ASSERT_CLK(a_empty_out_ready, !o_m_axis_tvalid |-> o_s_axis_tready, "input stalled with empty output")

    `ASSERT_CLK(a_ready_follows, i_m_axis_tready |-> o_s_axis_tready, "input stalled while output taken")

    `ASSERT_CLK(a_out_hold, o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast), "stalled output transfer changed")

endmodule

bind complex_pixel_magnitude_gray cpmg_checker u_cpmg_checker (.*);

>>> verif/tb_complex_pixel_magnitude_gray.sv
// Self-checking testbench for complex_pixel_magnitude_gray: random and corner pixels in,
// gray levels predicted by exact integer fourth roots and checked in order.
// Depends on cpmg_pkg and the complex_pixel_magnitude_gray RTL only.
module tb_complex_pixel_magnitude_gray;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [7:0] gray;
        logic       last;
    } t_gray_pixel;

    class gray_level_checker;
        t_gray_pixel expected_gray_q[$];
        int          mismatches;

        function new();
            mismatches = 0;
        endfunction

        function int centred_magnitude(logic [7:0] b);
            int v;
            v = int'(b) - int'(cpmg_pkg::CentreOffset);
            return (v < 0) ? -v : v;
        endfunction

        function logic [7:0] compute_gray_level(logic [7:0] re_byte, logic [7:0] im_byte);
            longint unsigned re;
            longint unsigned im;
            longint unsigned scaled;
            longint unsigned trial;
            longint unsigned root;
            re     = longint'(centred_magnitude(re_byte));
            im     = longint'(centred_magnitude(im_byte));
            scaled = (re * re + im * im) << cpmg_pkg::RootShift;
            root   = 0;
            for (int b = 8; b >= 0; b--) begin
                trial = root | (64'd1 << b);
                if (trial * trial * trial * trial <= scaled) begin
                    root = trial;
                end
            end
            if (root > longint'(cpmg_pkg::GrayMax)) begin
                root = longint'(cpmg_pkg::GrayMax);
            end
            return root[7:0];
        endfunction

        function void note_pixel(logic [7:0] re_byte, logic [7:0] im_byte, logic last);
            t_gray_pixel px;
            px.gray = compute_gray_level(re_byte, im_byte);
            px.last = last;
            expected_gray_q.push_back(px);
        endfunction

        task report_mismatch(string what);
            $display("[%0t] mismatch: %s", $time, what);
            mismatches++;
        endtask

        task check_result(logic [7:0] gray, logic last);
            t_gray_pixel px;
            if (expected_gray_q.size() == 0) begin
                report_mismatch($sformatf("unexpected transfer gray=%0d last=%0b", gray, last));
            end else begin
                px = expected_gray_q.pop_front();
                if (gray !== px.gray) begin
                    report_mismatch($sformatf("gray %0d, expected %0d", gray, px.gray));
                end
                if (last !== px.last) begin
                    report_mismatch($sformatf("last %0b, expected %0b", last, px.last));
                end
            end
        endtask

        function int pending_count();
            return expected_gray_q.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [15:0] i_s_axis_tdata;   // re_byte [7:0], im_byte [15:8]
    logic        i_s_axis_tlast;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [7:0]  o_m_axis_tdata;   // gray [7:0]
    logic        o_m_axis_tlast;

    gray_level_checker gray_chk;
    bit                long_hold_req;
    bit                long_hold_done;

    complex_pixel_magnitude_gray dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // A result depends only on earlier input transfers, so checking before noting is safe.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            gray_chk.check_result(o_m_axis_tdata, o_m_axis_tlast);
        end
        if (i_rst_n && i_s_axis_tvalid && o_s_axis_tready) begin
            gray_chk.note_pixel(i_s_axis_tdata[7:0], i_s_axis_tdata[15:8], i_s_axis_tlast);
        end
    end

    initial begin : output_side
        int ready_pct;
        int mode_left;
        int hold_left;
        ready_pct       = 100;
        mode_left       = 0;
        hold_left       = 0;
        long_hold_done  = 1'b0;
        i_m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_hold_req && !long_hold_done) begin
                long_hold_done = 1'b1;
                hold_left      = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_axis_tready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode_left = $urandom_range(30, 300);
                    case ($urandom_range(0, 3))
                        0: ready_pct = 100;
                        1: ready_pct = 75;
                        2: ready_pct = 50;
                        default: ready_pct = 12;
                    endcase
                end
                mode_left--;
                i_m_axis_tready <= ($urandom_range(1, 100) <= ready_pct);
            end
        end
    end

    task automatic send_pixel(logic [7:0] re_byte, logic [7:0] im_byte, logic last);
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {im_byte, re_byte};
        i_s_axis_tlast  <= last;
        do @(posedge i_clk); while (!o_s_axis_tready);
    endtask

    task automatic idle_input(int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            i_s_axis_tvalid <= 1'b0;
            i_s_axis_tdata  <= 16'($urandom);
            i_s_axis_tlast  <= 1'($urandom);
        end
    endtask

    task automatic wait_drained();
        idle_input(1);
        while (gray_chk.pending_count() != 0) @(posedge i_clk);
    endtask

    function automatic logic [7:0] random_byte();
        case ($urandom_range(0, 9))
            0: return ($urandom_range(0, 1) != 0) ? 8'd0 : 8'd255;
            1: return 8'($urandom_range(120, 136));
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic drive_random_pixels(int count, bit with_gaps);
        int burst;
        int sent;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(1, 40);
            for (int k = 0; k < burst && sent < count; k++) begin
                send_pixel(random_byte(), random_byte(), ($urandom_range(0, 15) == 0));
                sent++;
            end
            if (with_gaps && $urandom_range(0, 3) != 0) begin
                idle_input($urandom_range(1, 12));
            end
        end
    endtask

    initial begin : stimulus
        gray_chk        = new();
        long_hold_req   = 1'b0;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = 16'd0;
        i_s_axis_tlast  = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Full-scale corner, zero, other extremes, then small magnitudes, some exact fourth powers and mixed values.
        send_pixel(8'd0,   8'd0,   1'b0);
        send_pixel(8'd128, 8'd128, 1'b1);
        send_pixel(8'd255, 8'd255, 1'b0);
        send_pixel(8'd0,   8'd255, 1'b0);
        send_pixel(8'd255, 8'd0,   1'b1);
        send_pixel(8'd0,   8'd128, 1'b0);
        send_pixel(8'd128, 8'd0,   1'b0);
        send_pixel(8'd129, 8'd128, 1'b1);
        send_pixel(8'd127, 8'd127, 1'b0);
        send_pixel(8'd130, 8'd130, 1'b0);
        send_pixel(8'd136, 8'd136, 1'b1);
        send_pixel(8'd160, 8'd160, 1'b0);
        send_pixel(8'd146, 8'd146, 1'b0);
        send_pixel(8'd96,  8'd96,  1'b1);
        send_pixel(8'd1,   8'd254, 1'b0);
        send_pixel(8'd170, 8'd85,  1'b1);
        wait_drained();

        drive_random_pixels(500, 1'b1);
        wait_drained();

        long_hold_req = 1'b1;
        drive_random_pixels(500, 1'b0);
        drive_random_pixels(500, 1'b1);

        wait_drained();
        repeat (40) @(posedge i_clk);
        if (gray_chk.mismatches == 0) begin
            $display("tb_complex_pixel_magnitude_gray: PASS");
        end else begin
            $display("tb_complex_pixel_magnitude_gray: FAIL");
        end
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("tb_complex_pixel_magnitude_gray: FAIL");
        $finish;
    end

endmodule
